FILE: sv/sha1_pkg.sv
package sha1_pkg;

	localparam int ROUNDS = 80;
	localparam int BLOCK_WORDS = 16;
	localparam int DIGEST_WORDS = 5;
	localparam int COUNT_W = 61;

	localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
	localparam logic [2:0] LAST_WORD_IDX = 3'(DIGEST_WORDS - 1);

	localparam logic [0:0] OP_ABSORB = 1'b0;
	localparam logic [0:0] OP_FINISH = 1'b1;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	typedef struct packed {
		logic [0:0] opcode;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic [0:0]  last_word;
	} out_item_t;

	typedef struct packed {
		logic       absorb;
		logic       pad1;
		logic       pad2;
		logic       load;
		logic       round_en;
		logic       update;
		logic       clear;
		logic [6:0] round;
		logic [2:0] word_sel;
	} cmd_t;

	typedef struct packed {
		logic block_full;
		logic long_tail;
	} status_t;

endpackage

FILE: sv/sha1_ctrl.sv
module sha1_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                msg_valid,
	output logic                msg_ready,
	input  logic [0:0]          opcode,
	output logic                digest_valid,
	input  logic                digest_ready,
	output logic [2:0]          word_index,
	output logic [0:0]          last_word,
	output sha1_pkg::cmd_t      cmd,
	input  sha1_pkg::status_t   status
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_PAD1   = 7'b0000010,
		ST_PAD2   = 7'b0000100,
		ST_LOAD   = 7'b0001000,
		ST_ROUND  = 7'b0010000,
		ST_UPDATE = 7'b0100000,
		ST_EMIT   = 7'b1000000
	} state_t;

	state_t     state_q;
	logic [6:0] round_q;
	logic [2:0] word_q;
	logic       fin_q;
	logic       two_q;
	logic       msg_fire;
	logic       digest_fire;

	assign msg_ready    = (state_q == ST_IDLE);
	assign digest_valid = (state_q == ST_EMIT);
	assign msg_fire     = msg_valid && msg_ready;
	assign digest_fire  = digest_valid && digest_ready;
	assign word_index   = word_q;
	assign last_word    = 1'(word_q == sha1_pkg::LAST_WORD_IDX);

	always_comb begin
		cmd          = '0;
		cmd.absorb   = msg_fire && (opcode == sha1_pkg::OP_ABSORB);
		cmd.pad1     = (state_q == ST_PAD1);
		cmd.pad2     = (state_q == ST_PAD2);
		cmd.load     = (state_q == ST_LOAD);
		cmd.round_en = (state_q == ST_ROUND);
		cmd.update   = (state_q == ST_UPDATE);
		cmd.clear    = digest_fire && (word_q == sha1_pkg::LAST_WORD_IDX);
		cmd.round    = round_q;
		cmd.word_sel = word_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
			word_q  <= '0;
			fin_q   <= 1'b0;
			two_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (msg_fire) begin
						if (opcode == sha1_pkg::OP_FINISH) begin
							fin_q   <= 1'b1;
							state_q <= ST_PAD1;
						end else if (status.block_full) begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_PAD1: begin
					two_q   <= status.long_tail;
					state_q <= ST_LOAD;
				end
				ST_PAD2: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					round_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					round_q <= round_q + 7'd1;
					if (round_q == sha1_pkg::LAST_ROUND) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (fin_q && two_q) begin
						two_q   <= 1'b0;
						state_q <= ST_PAD2;
					end else if (fin_q) begin
						word_q  <= '0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (digest_fire) begin
						if (word_q == sha1_pkg::LAST_WORD_IDX) begin
							fin_q   <= 1'b0;
							word_q  <= '0;
							state_q <= ST_IDLE;
						end else begin
							word_q <= word_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (round_q <= sha1_pkg::LAST_ROUND))
		else $error("round counter beyond last round");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> !msg_ready)
		else $error("input taken while digest is being delivered");

	a_word_range: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> (word_q <= sha1_pkg::LAST_WORD_IDX))
		else $error("digest word index out of range");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(digest_fire && last_word == 1'b1) |=> (state_q == ST_IDLE && !fin_q))
		else $error("block did not return to idle after the last digest word");

endmodule

FILE: sv/sha1_dp.sv
module sha1_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          data_byte,
	input  sha1_pkg::cmd_t      cmd,
	output sha1_pkg::status_t   status,
	output logic [31:0]         digest_word
);

	logic [31:0] buf_q [sha1_pkg::BLOCK_WORDS];
	logic [31:0] w_q [sha1_pkg::BLOCK_WORDS];
	logic [31:0] cv_q [sha1_pkg::DIGEST_WORDS];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [sha1_pkg::COUNT_W-1:0] count_q;

	logic [5:0]  pos;
	logic [3:0]  wi;
	logic [1:0]  lane;
	logic        long_tail;
	logic [63:0] bit_len;
	logic [31:0] sched;
	logic [31:0] wt;
	logic [31:0] f;
	logic [31:0] k;
	logic [31:0] tmp;

	function automatic logic [31:0] put_byte(logic [31:0] word, logic [1:0] ln,
		logic [7:0] b);
		logic [31:0] r;
		r = word;
		case (ln)
			2'd0: r = {b, 24'h000000};
			2'd1: r[23:16] = b;
			2'd2: r[15:8] = b;
			2'd3: r[7:0] = b;
			default: r = word;
		endcase
		return r;
	endfunction

	assign pos       = count_q[5:0];
	assign wi        = pos[5:2];
	assign lane      = pos[1:0];
	assign long_tail = (pos > 6'd55);
	assign bit_len   = {count_q, 3'b000};

	assign status.block_full = (pos == 6'd63);
	assign status.long_tail  = long_tail;

	assign digest_word = cv_q[cmd.word_sel];

	assign sched = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign wt    = (cmd.round < 7'd16) ? w_q[0] : {sched[30:0], sched[31]};

	always_comb begin
		if (cmd.round < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = sha1_pkg::K0;
		end else if (cmd.round < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = sha1_pkg::K1;
		end else if (cmd.round < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = sha1_pkg::K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = sha1_pkg::K3;
		end
	end

	assign tmp = {a_q[26:0], a_q[31:27]} + f + e_q + k + wt;

	always_ff @(posedge clk) begin
		for (int i = 0; i < sha1_pkg::BLOCK_WORDS; i++) begin
			if (cmd.absorb && wi == 4'(i)) begin
				buf_q[i] <= put_byte(buf_q[i], lane, data_byte);
			end else if (cmd.pad1) begin
				if (wi == 4'(i)) begin
					buf_q[i] <= put_byte(buf_q[i], lane, sha1_pkg::PAD_BYTE);
				end else if (4'(i) > wi) begin
					if (!long_tail && i == 14) begin
						buf_q[i] <= bit_len[63:32];
					end else if (!long_tail && i == 15) begin
						buf_q[i] <= bit_len[31:0];
					end else begin
						buf_q[i] <= '0;
					end
				end
			end else if (cmd.pad2) begin
				if (i == 14) begin
					buf_q[i] <= bit_len[63:32];
				end else if (i == 15) begin
					buf_q[i] <= bit_len[31:0];
				end else begin
					buf_q[i] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < sha1_pkg::BLOCK_WORDS; i++) begin
				w_q[i] <= buf_q[i];
			end
			a_q <= cv_q[0];
			b_q <= cv_q[1];
			c_q <= cv_q[2];
			d_q <= cv_q[3];
			e_q <= cv_q[4];
		end else if (cmd.round_en) begin
			for (int i = 0; i < sha1_pkg::BLOCK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[sha1_pkg::BLOCK_WORDS-1] <= wt;
			a_q <= tmp;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
				cv_q[i] <= sha1_pkg::H_INIT[i];
			end
			count_q <= '0;
		end else begin
			if (cmd.update) begin
				cv_q[0] <= cv_q[0] + a_q;
				cv_q[1] <= cv_q[1] + b_q;
				cv_q[2] <= cv_q[2] + c_q;
				cv_q[3] <= cv_q[3] + d_q;
				cv_q[4] <= cv_q[4] + e_q;
			end else if (cmd.clear) begin
				for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
					cv_q[i] <= sha1_pkg::H_INIT[i];
				end
			end
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.absorb) begin
				count_q <= count_q + 61'd1;
			end
		end
	end

endmodule

FILE: sv/sha1_message_digest_top.sv
// SHA-1 hash engine that takes a message one byte per item and returns the
// 160-bit digest as five 32-bit words, most significant first, the fifth
// marked as last. Every 64th byte starts a block (block load, 80 rounds of
// the single round unit, chaining update) during which no item is taken.
// A finish item pads the message and runs one final block, or two when 56
// or more bytes of the last block are in use, then presents the five digest
// words, one per cycle while the receiver is ready. New input is taken again
// after the last word.
module sha1_message_digest_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  msg_valid,
	output logic                  msg_ready,
	input  sha1_pkg::in_item_t    msg,
	output logic                  digest_valid,
	input  logic                  digest_ready,
	output sha1_pkg::out_item_t   digest
);

	sha1_pkg::cmd_t    cmd;
	sha1_pkg::status_t status;
	logic [31:0]       word;
	logic [2:0]        word_index;
	logic [0:0]        last_word;

	sha1_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_ready    (msg_ready),
		.opcode       (msg.opcode),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.word_index   (word_index),
		.last_word    (last_word),
		.cmd          (cmd),
		.status       (status)
	);

	sha1_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (msg.data_byte),
		.cmd         (cmd),
		.status      (status),
		.digest_word (word)
	);

	assign digest.digest_word = word;
	assign digest.word_index  = word_index;
	assign digest.last_word   = last_word;

endmodule
